[design/rgbd_pkg.sv]
// Package for the RGB dimmer: transaction structs, command and register codes,
// and the fixed operand widths of the serial multiply-divide unit. No dependencies.
package rgbd_pkg;

  // Command codes carried in the kind field.
  localparam logic [2:0] KIND_TICK    = 3'd0;
  localparam logic [2:0] KIND_ON      = 3'd1;
  localparam logic [2:0] KIND_OFF     = 3'd2;
  localparam logic [2:0] KIND_TOGGLE  = 3'd3;
  localparam logic [2:0] KIND_COLOUR  = 3'd4;
  localparam logic [2:0] KIND_PERCENT = 3'd5;

  // Register indexes, taken from paddr[3:2].
  localparam int          ADDR_W         = 4;
  localparam logic [1:0]  REG_ACTIVE_LOW = 2'd0;
  localparam logic [1:0]  REG_FADE_TICKS = 2'd1;
  localparam logic [1:0]  REG_AUTO_OFF   = 2'd2;

  localparam logic [6:0]  PCT_FULL  = 7'd100;
  localparam logic [7:0]  LEVEL_MAX = 8'd255;

  // Operand widths of the multiply-divide unit, sized for the widest duty (10 bits).
  localparam int OPA_W  = 16;
  localparam int OPB_W  = 10;
  localparam int DIV_W  = 10;
  localparam int PROD_W = OPA_W + OPB_W;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [6:0] percent;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  duty_red;
    logic [7:0]  duty_green;
    logic [7:0]  duty_blue;
    logic        lamp_on;
    logic        fading;
    logic [31:0] off_remaining;
  } out_item_t;

  typedef struct packed {
    logic        active_low;
    logic [15:0] fade_ticks;
    logic [31:0] auto_off_ticks;
  } cfg_regs_t;

  // floor(a * b / c) request and response.
  typedef struct packed {
    logic             start;
    logic [OPA_W-1:0] a;
    logic [OPB_W-1:0] b;
    logic [DIV_W-1:0] c;
  } md_req_t;

  typedef struct packed {
    logic             done;
    logic [OPA_W-1:0] quot;
  } md_rsp_t;

endpackage

[design/rgbd_muldiv.sv]
// Serial multiply-divide unit: floor(a * b / c), one multiplier bit and then one
// quotient bit per cycle. Depends on rgbd_pkg.
module rgbd_muldiv (
  input  logic              clk,
  input  logic              rst_n,
  input  rgbd_pkg::md_req_t req,
  output rgbd_pkg::md_rsp_t rsp
);
  import rgbd_pkg::*;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_MUL  = 2'd1;
  localparam logic [1:0] PH_DIV  = 2'd2;
  localparam int         CNT_W   = $clog2(PROD_W + 1);

  logic [1:0]        phase_r, phase_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [PROD_W-1:0] mcand_r, mcand_nxt;
  logic [OPB_W-1:0]  mplier_r, mplier_nxt;
  logic [PROD_W-1:0] acc_r, acc_nxt;
  logic [DIV_W-1:0]  rem_r, rem_nxt;
  logic [DIV_W-1:0]  div_r, div_nxt;
  logic              done_r, done_nxt;
  logic [DIV_W:0]    trial;
  logic [DIV_W:0]    trial_sub;

  assign trial     = {rem_r, acc_r[PROD_W-1]};
  assign trial_sub = trial - {1'b0, div_r};

  always_comb begin
    phase_nxt  = phase_r;
    cnt_nxt    = cnt_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    acc_nxt    = acc_r;
    rem_nxt    = rem_r;
    div_nxt    = div_r;
    done_nxt   = 1'b0;
    case (phase_r)
      PH_IDLE: begin
        if (req.start) begin
          mcand_nxt  = PROD_W'(req.a);
          mplier_nxt = req.b;
          div_nxt    = req.c;
          acc_nxt    = '0;
          cnt_nxt    = CNT_W'(OPB_W);
          phase_nxt  = PH_MUL;
        end
      end
      PH_MUL: begin
        if (mplier_r[0]) begin
          acc_nxt = acc_r + mcand_r;
        end
        mcand_nxt  = {mcand_r[PROD_W-2:0], 1'b0};
        mplier_nxt = {1'b0, mplier_r[OPB_W-1:1]};
        cnt_nxt    = cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          cnt_nxt   = CNT_W'(PROD_W);
          rem_nxt   = '0;
          phase_nxt = PH_DIV;
        end
      end
      PH_DIV: begin
        // Restoring division: the quotient shifts in where the dividend leaves.
        if (trial >= {1'b0, div_r}) begin
          rem_nxt = trial_sub[DIV_W-1:0];
          acc_nxt = {acc_r[PROD_W-2:0], 1'b1};
        end else begin
          rem_nxt = trial[DIV_W-1:0];
          acc_nxt = {acc_r[PROD_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          done_nxt  = 1'b1;
          phase_nxt = PH_IDLE;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      cnt_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      done_r  <= done_nxt;
    end
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
    acc_r    <= acc_nxt;
    rem_r    <= rem_nxt;
    div_r    <= div_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = acc_r[OPA_W-1:0];

endmodule

[design/rgbd_regs.sv]
// APB-style register file for the dimmer: active-low, fade time and auto-off time.
// Depends on rgbd_pkg.
module rgbd_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rgbd_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output rgbd_pkg::cfg_regs_t        cfg
);
  import rgbd_pkg::*;

  logic        active_low_r;
  logic [15:0] fade_r;
  logic [31:0] auto_off_r;
  logic [1:0]  idx;
  logic        wr_en;

  assign idx    = paddr[ADDR_W-1:2];
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_low_r <= 1'b0;
      fade_r       <= '0;
      auto_off_r   <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_ACTIVE_LOW: active_low_r <= pwdata[0];
        REG_FADE_TICKS: fade_r       <= pwdata[15:0];
        REG_AUTO_OFF:   auto_off_r   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ACTIVE_LOW: prdata = {31'd0, active_low_r};
      REG_FADE_TICKS: prdata = {16'd0, fade_r};
      REG_AUTO_OFF:   prdata = auto_off_r;
      default:        prdata = '0;
    endcase
  end

  assign cfg.active_low     = active_low_r;
  assign cfg.fade_ticks     = fade_r;
  assign cfg.auto_off_ticks = auto_off_r;

endmodule

[design/rgb_led_dimmer_with_fade_core.sv]
// Each floor(a*b/c) runs on the shared serial multiply-divide unit. The worst item, a tick
// that steps a ramp and then fires auto-off into a new ramp, runs 13 of these operations.
// One transaction at a time: a new command is accepted only while the sequencer is idle.
// Reset (synchronous, rst_n low): lamp off, colour white, brightness 100 %, duties,
// ramp, timers and registers cleared.
module rgb_led_dimmer_with_fade_core #(
  parameter int DUTY_MAX = 255
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  rgbd_pkg::in_item_t          in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output rgbd_pkg::out_item_t         out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rgbd_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import rgbd_pkg::*;

  // Duty width follows DUTY_MAX; the duty fields of a result carry its low 8 bits.
  localparam int            DW   = $clog2(DUTY_MAX + 1);
  localparam logic [DW-1:0] DMAX = DW'(DUTY_MAX);

  // Sequencer states. LVL, DUTY, SPC and RAMP each run one multiply-divide.
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_TICK = 4'd1;
  localparam logic [3:0] S_LVL  = 4'd2;
  localparam logic [3:0] S_DUTY = 4'd3;
  localparam logic [3:0] S_CHK  = 4'd4;
  localparam logic [3:0] S_SPC  = 4'd5;
  localparam logic [3:0] S_RAMP = 4'd6;
  localparam logic [3:0] S_AUTO = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;

  cfg_regs_t cfg;
  md_req_t   md_req;
  md_rsp_t   md_rsp;

  rgbd_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rgbd_muldiv u_muldiv (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (md_req),
    .rsp   (md_rsp)
  );

  logic [3:0]          state_r, state_nxt;
  logic [1:0]          ch_r, ch_nxt;
  logic                issued_r, issued_nxt;
  logic                from_tick_r, from_tick_nxt;
  logic                on_r, on_nxt;
  logic [2:0][7:0]     colour_r, colour_nxt;
  logic [6:0]          bri_r, bri_nxt;
  logic [2:0][DW-1:0]  shown_r, shown_nxt;
  logic [2:0][DW-1:0]  start_r, start_nxt;
  logic [2:0][DW-1:0]  goal_r, goal_nxt;
  logic [2:0][DW-1:0]  tgt_r, tgt_nxt;
  logic [7:0]          lvl_r, lvl_nxt;
  logic [DW-1:0]       index_r, index_nxt;
  logic [DW-1:0]       steps_r, steps_nxt;
  logic [15:0]         spacing_r, spacing_nxt;
  logic [15:0]         scount_r, scount_nxt;
  logic [31:0]         elapsed_r, elapsed_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_data_r, out_data_nxt;

  // Distance of each wanted duty from the shown one, and the largest of the three.
  logic [2:0][DW-1:0]  chan_gap;
  logic [DW-1:0]       dist_01;
  logic [DW-1:0]       dist_max;
  // Ramp helpers for the channel in hand.
  logic                ramp_up;
  logic [DW-1:0]       ramp_span;
  logic [DW-1:0]       quot_d;
  logic [15:0]         scount_dec;
  logic [31:0]         elapsed_inc;
  logic [31:0]         remaining;
  logic                md_op;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      chan_gap[c] = (tgt_r[c] > shown_r[c]) ? (tgt_r[c] - shown_r[c]) :
                                              (shown_r[c] - tgt_r[c]);
    end
    dist_01  = (chan_gap[0] > chan_gap[1]) ? chan_gap[0] : chan_gap[1];
    dist_max = (dist_01 > chan_gap[2]) ? dist_01 : chan_gap[2];
  end

  assign ramp_up     = goal_r[ch_r] >= start_r[ch_r];
  assign ramp_span   = ramp_up ? (goal_r[ch_r] - start_r[ch_r]) : (start_r[ch_r] - goal_r[ch_r]);
  assign quot_d      = md_rsp.quot[DW-1:0];
  assign scount_dec  = (scount_r != 16'd0) ? (scount_r - 16'd1) : 16'd0;
  assign elapsed_inc = (elapsed_r != '1) ? (elapsed_r + 32'd1) : elapsed_r;
  assign remaining   = (on_r && (cfg.auto_off_ticks != 32'd0) &&
                        (elapsed_r < cfg.auto_off_ticks)) ?
                       (cfg.auto_off_ticks - elapsed_r) : 32'd0;

  // Operands for the shared unit. The level is forced to zero while the lamp is off.
  assign md_op = (state_r == S_LVL) || (state_r == S_DUTY) ||
                 (state_r == S_SPC) || (state_r == S_RAMP);

  always_comb begin
    md_req.start = md_op && !issued_r;
    md_req.a     = '0;
    md_req.b     = '0;
    md_req.c     = '0;
    case (state_r)
      S_LVL: begin
        md_req.a = on_r ? OPA_W'(colour_r[ch_r]) : '0;
        md_req.b = OPB_W'(bri_r);
        md_req.c = DIV_W'(PCT_FULL);
      end
      S_DUTY: begin
        md_req.a = OPA_W'(lvl_r);
        md_req.b = OPB_W'(DMAX);
        md_req.c = DIV_W'(LEVEL_MAX);
      end
      S_SPC: begin
        md_req.a = cfg.fade_ticks;
        md_req.b = OPB_W'(1);
        md_req.c = DIV_W'(steps_r);
      end
      S_RAMP: begin
        md_req.a = OPA_W'(ramp_span);
        md_req.b = OPB_W'(index_r);
        md_req.c = DIV_W'(steps_r);
      end
      default: ;
    endcase
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    ch_nxt        = ch_r;
    issued_nxt    = issued_r;
    from_tick_nxt = from_tick_r;
    on_nxt        = on_r;
    colour_nxt    = colour_r;
    bri_nxt       = bri_r;
    shown_nxt     = shown_r;
    start_nxt     = start_r;
    goal_nxt      = goal_r;
    tgt_nxt       = tgt_r;
    lvl_nxt       = lvl_r;
    index_nxt     = index_r;
    steps_nxt     = steps_r;
    spacing_nxt   = spacing_r;
    scount_nxt    = scount_r;
    elapsed_nxt   = elapsed_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;

    if (md_req.start) begin
      issued_nxt = 1'b1;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          from_tick_nxt = (in_data.kind == KIND_TICK);
          ch_nxt        = 2'd0;
          case (in_data.kind)
            KIND_TICK: begin
              state_nxt = S_TICK;
            end
            KIND_ON: begin
              on_nxt      = 1'b1;
              elapsed_nxt = '0;
              state_nxt   = S_LVL;
            end
            KIND_OFF: begin
              on_nxt    = 1'b0;
              state_nxt = S_LVL;
            end
            KIND_TOGGLE: begin
              on_nxt = !on_r;
              if (!on_r) begin
                elapsed_nxt = '0;
              end
              state_nxt = S_LVL;
            end
            KIND_COLOUR: begin
              colour_nxt = {in_data.blue, in_data.green, in_data.red};
              state_nxt  = on_r ? S_LVL : S_OUT;
            end
            KIND_PERCENT: begin
              bri_nxt   = (in_data.percent > PCT_FULL) ? PCT_FULL : in_data.percent;
              state_nxt = on_r ? S_LVL : S_OUT;
            end
            default: begin
              state_nxt = S_OUT;
            end
          endcase
        end
      end

      // A running ramp counts down its spacing and shows the next step at zero.
      S_TICK: begin
        state_nxt = S_AUTO;
        if (index_r < steps_r) begin
          if (scount_dec == 16'd0) begin
            index_nxt  = index_r + DW'(1);
            scount_nxt = spacing_r;
            ch_nxt     = 2'd0;
            state_nxt  = S_RAMP;
          end else begin
            scount_nxt = scount_dec;
          end
        end
      end

      S_LVL: begin
        if (md_rsp.done) begin
          issued_nxt = 1'b0;
          lvl_nxt    = md_rsp.quot[7:0];
          state_nxt  = S_DUTY;
        end
      end

      S_DUTY: begin
        if (md_rsp.done) begin
          issued_nxt   = 1'b0;
          tgt_nxt[ch_r] = cfg.active_low ? (DMAX - quot_d) : quot_d;
          if (ch_r == 2'd2) begin
            state_nxt = S_CHK;
          end else begin
            ch_nxt    = ch_r + 2'd1;
            state_nxt = S_LVL;
          end
        end
      end

      // Either jump to the wanted duties or start a ramp from what is shown now.
      S_CHK: begin
        if ((cfg.fade_ticks != 16'd0) && (dist_max != '0)) begin
          start_nxt = shown_r;
          goal_nxt  = tgt_r;
          steps_nxt = dist_max;
          state_nxt = S_SPC;
        end else begin
          shown_nxt  = tgt_r;
          index_nxt  = '0;
          steps_nxt  = '0;
          scount_nxt = '0;
          state_nxt  = S_OUT;
        end
      end

      S_SPC: begin
        if (md_rsp.done) begin
          issued_nxt  = 1'b0;
          spacing_nxt = md_rsp.quot;
          if (md_rsp.quot == 16'd0) begin
            shown_nxt  = goal_r;
            index_nxt  = steps_r;
            scount_nxt = '0;
            state_nxt  = S_OUT;
          end else begin
            index_nxt  = DW'(1);
            scount_nxt = md_rsp.quot;
            ch_nxt     = 2'd0;
            state_nxt  = S_RAMP;
          end
        end
      end

      // Step value is start plus or minus floor(|diff| * index / steps).
      S_RAMP: begin
        if (md_rsp.done) begin
          issued_nxt     = 1'b0;
          shown_nxt[ch_r] = ramp_up ? (start_r[ch_r] + quot_d) : (start_r[ch_r] - quot_d);
          if (ch_r == 2'd2) begin
            state_nxt = from_tick_r ? S_AUTO : S_OUT;
          end else begin
            ch_nxt = ch_r + 2'd1;
          end
        end
      end

      // The on-time counter saturates; reaching the auto-off time switches off.
      S_AUTO: begin
        state_nxt = S_OUT;
        if (on_r) begin
          elapsed_nxt = elapsed_inc;
          if ((cfg.auto_off_ticks != 32'd0) && (elapsed_inc >= cfg.auto_off_ticks)) begin
            on_nxt        = 1'b0;
            from_tick_nxt = 1'b0;
            ch_nxt        = 2'd0;
            state_nxt     = S_LVL;
          end
        end
      end

      // The result waits here only while an earlier one has not been taken.
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.duty_red      = shown_r[0][7:0];
          out_data_nxt.duty_green    = shown_r[1][7:0];
          out_data_nxt.duty_blue     = shown_r[2][7:0];
          out_data_nxt.lamp_on       = on_r;
          out_data_nxt.fading        = index_r < steps_r;
          out_data_nxt.off_remaining = remaining;
          state_nxt                  = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ch_r        <= '0;
      issued_r    <= 1'b0;
      from_tick_r <= 1'b0;
      on_r        <= 1'b0;
      colour_r    <= {3{LEVEL_MAX}};
      bri_r       <= PCT_FULL;
      shown_r     <= '0;
      start_r     <= '0;
      goal_r      <= '0;
      index_r     <= '0;
      steps_r     <= '0;
      spacing_r   <= '0;
      scount_r    <= '0;
      elapsed_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ch_r        <= ch_nxt;
      issued_r    <= issued_nxt;
      from_tick_r <= from_tick_nxt;
      on_r        <= on_nxt;
      colour_r    <= colour_nxt;
      bri_r       <= bri_nxt;
      shown_r     <= shown_nxt;
      start_r     <= start_nxt;
      goal_r      <= goal_nxt;
      index_r     <= index_nxt;
      steps_r     <= steps_nxt;
      spacing_r   <= spacing_nxt;
      scount_r    <= scount_nxt;
      elapsed_r   <= elapsed_nxt;
      out_valid_r <= out_valid_nxt;
    end
    tgt_r      <= tgt_nxt;
    lvl_r      <= lvl_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
